FILE: sv/qvr_pkg.sv
package qvr_pkg;

  localparam int VEC_W = 24;
  localparam int QW    = 16;
  localparam int PW    = QW + VEC_W;
  localparam int CW    = PW + 2;
  localparam int SQW   = 2 * QW;
  localparam int SW    = 2 * QW + 2;
  localparam int NRMW  = 2 * QW + 1;
  localparam int NW    = VEC_W + 36;
  localparam int AW    = NW + 2;
  localparam int DW    = NRMW + 1;

  typedef struct packed {
    logic signed [QW-1:0]    quat_x;
    logic signed [QW-1:0]    quat_y;
    logic signed [QW-1:0]    quat_z;
    logic signed [QW-1:0]    quat_w;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    zero_quat;
    logic                    saturated;
  } qvr_out_t;

  typedef struct packed {
    logic                         valid;
    logic                         zero;
    logic [NRMW-1:0]              norm;
    logic [2:0][NW-1:0]           num;
  } qvr_num_t;

endpackage

FILE: sv/qvr_numer.sv
module qvr_numer import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  qvr_in_t  in_item,
  output qvr_num_t num_o
);

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic signed [PW-1:0]    p_r   [3][3];
  logic signed [SQW-1:0]   sq_r  [4];
  logic signed [QW-1:0]    u1_r  [3];
  logic signed [QW-1:0]    w1_r;
  logic signed [VEC_W-1:0] vv1_r [3];

  logic signed [SW-1:0]    s_r;
  logic signed [SW-1:0]    nsum;
  logic [NRMW-1:0]         n2_r, n3_r, n4_r;
  logic                    z2_r, z3_r, z4_r;
  logic signed [CW-1:0]    d_r;
  logic signed [CW-1:0]    c_r   [3];
  logic signed [QW-1:0]    u2_r  [3];
  logic signed [QW-1:0]    w2_r;
  logic signed [VEC_W-1:0] vv2_r [3];

  logic signed [NW-1:0]    ts_r [3];
  logic signed [NW-1:0]    td_r [3];
  logic signed [NW-1:0]    tc_r [3];
  logic signed [NW-1:0]    num_r [3];

  logic signed [QW-1:0]    u_in [3];
  logic signed [VEC_W-1:0] v_in [3];

  assign u_in[0] = in_item.quat_x;
  assign u_in[1] = in_item.quat_y;
  assign u_in[2] = in_item.quat_z;
  assign v_in[0] = in_item.vec_x;
  assign v_in[1] = in_item.vec_y;
  assign v_in[2] = in_item.vec_z;

  assign nsum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_r[i][j] <= PW'(u_in[i]) * PW'(v_in[j]);
      end
      sq_r[i] <= SQW'(u_in[i]) * SQW'(u_in[i]);
      u1_r[i] <= u_in[i];
      vv1_r[i] <= v_in[i];
    end
    sq_r[3] <= SQW'(in_item.quat_w) * SQW'(in_item.quat_w);
    w1_r    <= in_item.quat_w;

    s_r  <= SW'(sq_r[3]) - (SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]));
    n2_r <= nsum[NRMW-1:0];
    z2_r <= (nsum == '0);
    d_r  <= CW'(p_r[0][0]) + CW'(p_r[1][1]) + CW'(p_r[2][2]);
    c_r[0] <= CW'(p_r[1][2]) - CW'(p_r[2][1]);
    c_r[1] <= CW'(p_r[2][0]) - CW'(p_r[0][2]);
    c_r[2] <= CW'(p_r[0][1]) - CW'(p_r[1][0]);
    u2_r  <= u1_r;
    w2_r  <= w1_r;
    vv2_r <= vv1_r;

    for (int i = 0; i < 3; i++) begin
      ts_r[i] <= NW'(s_r) * NW'(vv2_r[i]);
      td_r[i] <= NW'(d_r) * NW'(u2_r[i]);
      tc_r[i] <= NW'(w2_r) * NW'(c_r[i]);
    end
    n3_r <= n2_r;
    z3_r <= z2_r;

    for (int i = 0; i < 3; i++) begin
      num_r[i] <= ts_r[i] + (td_r[i] <<< 1) + (tc_r[i] <<< 1);
    end
    n4_r <= n3_r;
    z4_r <= z3_r;
  end

  always_comb begin
    num_o.valid = v4_r;
    num_o.zero  = z4_r;
    num_o.norm  = n4_r;
    for (int i = 0; i < 3; i++) begin
      num_o.num[i] = num_r[i];
    end
  end

endmodule

FILE: sv/qvr_div.sv
module qvr_div import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  qvr_num_t num_i,
  output logic     out_valid,
  output qvr_out_t out_res
);

  localparam int NS = VEC_W + 1;

  logic                    va_r;
  logic                    za_r;
  logic [DW-1:0]           da_r;
  logic signed [AW-1:0]    a_r [3];

  logic                    vs_r [NS];
  logic                    zs_r [NS];
  logic [DW-1:0]           ds_r [NS];
  logic                    lo_r [NS][3];
  logic                    hi_r [NS][3];
  logic [DW-1:0]           rem_r [NS][3];
  logic [VEC_W-1:0]        low_r [NS][3];
  logic [VEC_W-1:0]        quo_r [NS][3];

  logic                    vo_r;
  qvr_out_t                res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        vs_r[k] <= 1'b0;
      end
    end else begin
      va_r    <= num_i.valid;
      vs_r[0] <= va_r;
      for (int k = 1; k < NS; k++) begin
        vs_r[k] <= vs_r[k-1];
      end
      vo_r <= vs_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    za_r <= num_i.zero;
    da_r <= {num_i.norm, 1'b0};
    for (int i = 0; i < 3; i++) begin
      a_r[i] <= (AW'($signed(num_i.num[i])) <<< 1)
              + $signed({{(AW-NRMW){1'b0}}, num_i.norm})
              + ($signed({{(AW-NRMW){1'b0}}, num_i.norm}) <<< VEC_W);
    end

    zs_r[0] <= za_r;
    ds_r[0] <= da_r;
    for (int i = 0; i < 3; i++) begin
      lo_r[0][i]  <= a_r[i][AW-1];
      hi_r[0][i]  <= !a_r[i][AW-1] &&
                     (a_r[i] >= $signed({{(AW-DW-VEC_W){1'b0}}, da_r, {VEC_W{1'b0}}}));
      rem_r[0][i] <= a_r[i][VEC_W+DW-1:VEC_W];
      low_r[0][i] <= a_r[i][VEC_W-1:0];
      quo_r[0][i] <= '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [DW:0]   sh   [3];
    logic [DW+1:0] diff [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i]   = {rem_r[k-1][i], low_r[k-1][i][VEC_W-1]};
        diff[i] = {1'b0, sh[i]} - {2'b00, ds_r[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      zs_r[k] <= zs_r[k-1];
      ds_r[k] <= ds_r[k-1];
      for (int i = 0; i < 3; i++) begin
        lo_r[k][i]  <= lo_r[k-1][i];
        hi_r[k][i]  <= hi_r[k-1][i];
        rem_r[k][i] <= diff[i][DW+1] ? sh[i][DW-1:0] : diff[i][DW-1:0];
        low_r[k][i] <= low_r[k-1][i] << 1;
        quo_r[k][i] <= {quo_r[k-1][i][VEC_W-2:0], !diff[i][DW+1]};
      end
    end
  end

  logic [VEC_W-1:0] rot [3];
  logic             any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (zs_r[NS-1]) begin
        rot[i] = '0;
      end else if (hi_r[NS-1][i]) begin
        rot[i] = {1'b0, {(VEC_W-1){1'b1}}};
      end else if (lo_r[NS-1][i]) begin
        rot[i] = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
        rot[i] = {~quo_r[NS-1][i][VEC_W-1], quo_r[NS-1][i][VEC_W-2:0]};
      end
      any_sat = any_sat | hi_r[NS-1][i] | lo_r[NS-1][i];
    end
  end

  always_ff @(posedge clk) begin
    res_r.rot_x     <= rot[0];
    res_r.rot_y     <= rot[1];
    res_r.rot_z     <= rot[2];
    res_r.zero_quat <= zs_r[NS-1];
    res_r.saturated <= any_sat & !zs_r[NS-1];
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule

FILE: sv/quaternion_vector_rotate_core.sv
// Channel  | Ports                  | Handshake
// input    | in_item                | taken when start is high and busy is low
// result   | out_item               | valid for one cycle while out_strobe is high
//
// From start to out_strobe, each item passes through four stages that form the
// rotation numerator with 16 by 24, 34 by 24 and 42 by 16 multipliers, and then a
// restoring divider by twice the squared norm retiring one quotient bit per stage.
// A new item can be started in every cycle, so busy is always low.
// Reset clears only the valid bits; the result side cannot stall.
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qvr_in_t  in_item,
  output logic     out_strobe,
  output qvr_out_t out_item
);

  qvr_num_t num;

  assign busy = 1'b0;

  qvr_numer u_numer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & !busy),
    .in_item  (in_item),
    .num_o    (num)
  );

  qvr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_i     (num),
    .out_valid (out_strobe),
    .out_res   (out_item)
  );

endmodule

FILE: tb/tb.sv
module tb import qvr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  qvr_in_t in_item = '0;
  logic out_strobe;
  qvr_out_t out_item;

  qvr_out_t rotations_due[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  quaternion_vector_rotate_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic qvr_out_t rotate_vector(qvr_in_t it);
    qvr_out_t r;
    longint ux, uy, uz, w, n, s, d, cx, cy, cz, v[3], num[3], lim_lo, lim_hi, res;
    r = '0;
    ux = it.quat_x; uy = it.quat_y; uz = it.quat_z; w = it.quat_w;
    v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
    n = ux*ux + uy*uy + uz*uz + w*w;
    if (n == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    s = w*w - (ux*ux + uy*uy + uz*uz);
    d = ux*v[0] + uy*v[1] + uz*v[2];
    cx = uy*v[2] - uz*v[1];
    cy = uz*v[0] - ux*v[2];
    cz = ux*v[1] - uy*v[0];
    num[0] = s*v[0] + 2*d*ux + 2*w*cx;
    num[1] = s*v[1] + 2*d*uy + 2*w*cy;
    num[2] = s*v[2] + 2*d*uz + 2*w*cz;
    lim_lo = -(longint'(1) <<< (VEC_W-1));
    lim_hi = (longint'(1) <<< (VEC_W-1)) - 1;
    for (int i = 0; i < 3; i++) begin
      res = fdiv(2*num[i] + n, 2*n);
      if (res > lim_hi) begin res = lim_hi; r.saturated = 1'b1; end
      if (res < lim_lo) begin res = lim_lo; r.saturated = 1'b1; end
      if (i == 0) r.rot_x = res[VEC_W-1:0];
      else if (i == 1) r.rot_y = res[VEC_W-1:0];
      else r.rot_z = res[VEC_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    qvr_out_t want;
    if (rst_n && out_strobe) begin
      if (rotations_due.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = rotations_due.pop_front();
        if (out_item.rot_x !== want.rot_x) report_mismatch("rot_x", out_item.rot_x, want.rot_x);
        if (out_item.rot_y !== want.rot_y) report_mismatch("rot_y", out_item.rot_y, want.rot_y);
        if (out_item.rot_z !== want.rot_z) report_mismatch("rot_z", out_item.rot_z, want.rot_z);
        if (out_item.zero_quat !== want.zero_quat)
          report_mismatch("zero_quat", out_item.zero_quat, want.zero_quat);
        if (out_item.saturated !== want.saturated)
          report_mismatch("saturated", out_item.saturated, want.saturated);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(qvr_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    rotations_due.push_back(rotate_vector(it));
  endtask

  function automatic qvr_in_t make_item(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
    qvr_in_t it;
    it.quat_x = QW'(qx); it.quat_y = QW'(qy); it.quat_z = QW'(qz); it.quat_w = QW'(qw);
    it.vec_x = VEC_W'(vx); it.vec_y = VEC_W'(vy); it.vec_z = VEC_W'(vz);
    return it;
  endfunction

  function automatic logic [QW-1:0] rand_quat_part();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(16384 - $urandom_range(32768));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec_part();
    case ($urandom_range(4))
      0: return {1'b1, {(VEC_W-1){1'b0}}};
      1: return {1'b0, {(VEC_W-1){1'b1}}};
      2: return VEC_W'($urandom_range(2000)) - VEC_W'(1000);
      default: return VEC_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    int mx, mn, vmx, vmn;
    mx = 32767; mn = -32768; vmx = 8388607; vmn = -8388608;
    send_item(make_item(0, 0, 0, 0, vmx, vmn, 5));
    send_item(make_item(0, 0, 0, 16384, vmx, vmn, 123));
    send_item(make_item(0, 0, 0, mn, vmn, vmn, vmn));
    send_item(make_item(mx, 0, 0, 0, 1, vmx, vmn));
    send_item(make_item(0, mn, 0, 0, vmx, 1, -1));
    send_item(make_item(0, 0, mx, 0, vmn, vmx, 0));
    send_item(make_item(11585, 0, 0, 11585, 100, 200, 300));
    send_item(make_item(9459, 9459, 9459, 9459, vmx, vmx, 0));
    send_item(make_item(9459, 9459, 9459, 9459, vmn, vmn, vmn));
    send_item(make_item(mx, mx, mx, mx, vmx, vmx, vmx));
    send_item(make_item(mn, mn, mn, mn, vmn, vmn, vmn));
    send_item(make_item(mn, mx, mn, mx, vmx, vmn, vmx));
    send_item(make_item(1, 0, 0, 0, 3, 4, 5));
    send_item(make_item(0, 0, 0, 1, -1, 0, 1));
    send_item(make_item(1, 1, 0, 0, 1, 0, 0));
    send_item(make_item(3, 0, 0, 1, 1, 1, 1));
    send_item(make_item(5000, -7000, 12000, 3000, vmx, 0, vmn));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int count);
    qvr_in_t it;
    repeat (count) begin
      it = '0;
      if ($urandom_range(15) != 0) begin
        it.quat_x = rand_quat_part();
        it.quat_y = rand_quat_part();
        it.quat_z = rand_quat_part();
        it.quat_w = rand_quat_part();
      end
      it.vec_x = rand_vec_part(); it.vec_y = rand_vec_part(); it.vec_z = rand_vec_part();
      send_item(it);
    end
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 22;
    test_directed();
    test_random(170);
    idle_pct = 67;
    test_random(170);
    idle_pct = 0;
    test_random(170);
    start <= 1'b0;
    waited = 0;
    while (rotations_due.size() != 0 && waited < 10 * WATCHDOG_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && rotations_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
